[src/aotcf_pkg.sv]
package aotcf_pkg;

  localparam int DEPTH       = 16;
  localparam int HANDLE_BITS = 16;

  localparam int HANDLE_W = 16;
  localparam int STAMP_W  = 32;
  localparam int STATUS_W = 2;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int STORE_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic {
    KIND_FIRST  = 1'b0,
    KIND_SECOND = 1'b1
  } kind_t;

endpackage

[src/age_ordered_two_class_fifo_top.sv]
// Two-class FIFO with oldest-first dequeue.
// Input channel (in_valid/in_ready) carries one request per transfer:
// operation selects enqueue or dequeue; kind and item_handle give the class
// and handle of an enqueued item and are ignored on a dequeue.
// Every request gives exactly one result on the output channel
// (out_valid/out_ready): status, out_kind, out_handle and out_stamp.
// An enqueue stamps the handle with a shared 32-bit wrapping counter; a
// dequeue returns the head whose stamp is older (ties go to the first class).
// The request is worked out in the cycle it is taken and the result sits in
// the output register from the next cycle on.
// Throughput is one request per cycle while the receiver does not stall; the
// queue state is read and updated by one pass of logic on the head and tail
// entries and the stamp counter. A new request is taken whenever the output
// register is empty or is being drained in the same cycle, so a stalled
// receiver holds the result and stops the input side after at most one result is waiting.
// Reset (synchronous, active high) empties both queues, zeroes the stamp
// counter and drops out_valid; queue storage is not cleared.
module age_ordered_two_class_fifo_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               operation,
  input  logic                               kind,
  input  logic [aotcf_pkg::HANDLE_W-1:0]     item_handle,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [aotcf_pkg::STATUS_W-1:0]     status,
  output logic                               out_kind,
  output logic [aotcf_pkg::HANDLE_W-1:0]     out_handle,
  output logic [aotcf_pkg::STAMP_W-1:0]      out_stamp
);
  import aotcf_pkg::*;

  logic [STORE_W-1:0] first_handles  [DEPTH];
  logic [STAMP_W-1:0] first_stamps   [DEPTH];
  logic [STORE_W-1:0] second_handles [DEPTH];
  logic [STAMP_W-1:0] second_stamps  [DEPTH];

  logic [PTR_W-1:0]   first_head, first_tail, second_head, second_tail;
  logic [CNT_W-1:0]   first_count, second_count;
  logic [STAMP_W-1:0] next_stamp;

  logic               in_fire;
  logic               first_empty, second_empty, first_full, second_full;
  logic [STAMP_W-1:0] first_head_stamp, second_head_stamp, stamp_diff;
  logic               take_first;
  logic               do_enq_first, do_enq_second, do_deq_first, do_deq_second;
  status_t            status_next;
  logic               out_kind_next;
  logic [HANDLE_W-1:0] out_handle_next;
  logic [STAMP_W-1:0] out_stamp_next;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign first_empty  = (first_count == '0);
  assign second_empty = (second_count == '0);
  assign first_full   = (first_count == CNT_W'(DEPTH));
  assign second_full  = (second_count == CNT_W'(DEPTH));

  assign first_head_stamp  = first_stamps[first_head];
  assign second_head_stamp = second_stamps[second_head];
  assign stamp_diff        = second_head_stamp - first_head_stamp;

  always_comb begin
    take_first      = 1'b0;
    do_enq_first    = 1'b0;
    do_enq_second   = 1'b0;
    do_deq_first    = 1'b0;
    do_deq_second   = 1'b0;
    status_next     = ST_EMPTY;
    out_kind_next   = KIND_FIRST;
    out_handle_next = '0;
    out_stamp_next  = '0;
    if (operation == OP_ENQUEUE) begin
      if ((kind == KIND_FIRST && first_full) || (kind == KIND_SECOND && second_full)) begin
        status_next = ST_FULL;
      end else begin
        status_next    = ST_ENQUEUED;
        out_stamp_next = next_stamp;
        do_enq_first   = in_fire && (kind == KIND_FIRST);
        do_enq_second  = in_fire && (kind == KIND_SECOND);
      end
    end else if (!(first_empty && second_empty)) begin
      if (first_empty) begin
        take_first = 1'b0;
      end else if (second_empty) begin
        take_first = 1'b1;
      end else begin
        // second class only wins when strictly older
        take_first = !stamp_diff[STAMP_W-1];
      end
      status_next = ST_DEQUEUED;
      if (take_first) begin
        out_kind_next   = KIND_FIRST;
        out_handle_next = HANDLE_W'(first_handles[first_head]);
        out_stamp_next  = first_head_stamp;
        do_deq_first    = in_fire;
      end else begin
        out_kind_next   = KIND_SECOND;
        out_handle_next = HANDLE_W'(second_handles[second_head]);
        out_stamp_next  = second_head_stamp;
        do_deq_second   = in_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_enq_first) begin
      first_handles[first_tail] <= item_handle[STORE_W-1:0];
      first_stamps[first_tail]  <= next_stamp;
    end
    if (do_enq_second) begin
      second_handles[second_tail] <= item_handle[STORE_W-1:0];
      second_stamps[second_tail]  <= next_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_head   <= '0;
      first_tail   <= '0;
      first_count  <= '0;
      second_head  <= '0;
      second_tail  <= '0;
      second_count <= '0;
      next_stamp   <= '0;
    end else begin
      if (do_enq_first || do_enq_second) begin
        next_stamp <= next_stamp + STAMP_W'(1);
      end
      if (do_enq_first) begin
        first_tail  <= ptr_inc(first_tail);
        first_count <= first_count + CNT_W'(1);
      end
      if (do_deq_first) begin
        first_head  <= ptr_inc(first_head);
        first_count <= first_count - CNT_W'(1);
      end
      if (do_enq_second) begin
        second_tail  <= ptr_inc(second_tail);
        second_count <= second_count + CNT_W'(1);
      end
      if (do_deq_second) begin
        second_head  <= ptr_inc(second_head);
        second_count <= second_count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status     <= status_next;
      out_kind   <= out_kind_next;
      out_handle <= out_handle_next;
      out_stamp  <= out_stamp_next;
    end
  end

`ifndef SYNTHESIS
  a_first_count_bound: assert property (@(posedge clk) disable iff (rst)
    first_count <= CNT_W'(DEPTH))
    else $error("first queue count above depth");

  a_second_count_bound: assert property (@(posedge clk) disable iff (rst)
    second_count <= CNT_W'(DEPTH))
    else $error("second queue count above depth");

  a_stamp_advance: assert property (@(posedge clk) disable iff (rst)
    (do_enq_first || do_enq_second) |=> next_stamp == $past(next_stamp) + STAMP_W'(1))
    else $error("stamp counter did not advance on enqueue");

  a_deq_one_side: assert property (@(posedge clk) disable iff (rst)
    !(do_deq_first && do_deq_second) && !(do_enq_first && do_enq_second))
    else $error("both queues updated by one transfer");
`endif

endmodule

[test/age_ordered_two_class_fifo_top_tb.sv]
`timescale 1ns / 100ps

module age_ordered_two_class_fifo_top_tb;
  import aotcf_pkg::*;

  typedef struct {
    status_t             status;
    kind_t               kind;
    logic [HANDLE_W-1:0] handle;
    logic [STAMP_W-1:0]  stamp;
  } fifo_result_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic                operation;
  logic                kind;
  logic [HANDLE_W-1:0] item_handle;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic                out_kind;
  logic [HANDLE_W-1:0] out_handle;
  logic [STAMP_W-1:0]  out_stamp;

  age_ordered_two_class_fifo_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .kind        (kind),
    .item_handle (item_handle),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .out_kind    (out_kind),
    .out_handle  (out_handle),
    .out_stamp   (out_stamp)
  );

  // shadow copy of both class queues and the stamp counter
  logic [STORE_W-1:0] queued_handle [2][DEPTH];
  logic [STAMP_W-1:0] queued_stamp  [2][DEPTH];
  int unsigned        queue_head    [2];
  int unsigned        queue_count   [2];
  logic [STAMP_W-1:0] stamp_counter;

  fifo_result_t expected_responses [$];
  int           mismatch_count;
  logic         steady;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic fifo_result_t apply_request(op_t op, kind_t k, logic [HANDLE_W-1:0] h);
    fifo_result_t       r;
    int                 c;
    int unsigned        idx;
    logic [STAMP_W-1:0] age_gap;
    r.status = ST_EMPTY;
    r.kind   = KIND_FIRST;
    r.handle = '0;
    r.stamp  = '0;
    if (op == OP_ENQUEUE) begin
      c = int'(k);
      if (queue_count[c] >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        idx = (queue_head[c] + queue_count[c]) % DEPTH;
        queued_handle[c][idx] = h[STORE_W-1:0];
        queued_stamp[c][idx]  = stamp_counter;
        queue_count[c]++;
        r.status = ST_ENQUEUED;
        r.stamp  = stamp_counter;
        stamp_counter = stamp_counter + 1'b1;
      end
    end else if (queue_count[0] != 0 || queue_count[1] != 0) begin
      if (queue_count[0] == 0) begin
        c = 1;
      end else if (queue_count[1] == 0) begin
        c = 0;
      end else begin
        // second head wins only when strictly older, modulo wrap
        age_gap = queued_stamp[1][queue_head[1]] - queued_stamp[0][queue_head[0]];
        c = age_gap[STAMP_W-1] ? 1 : 0;
      end
      idx = queue_head[c];
      r.status = ST_DEQUEUED;
      r.kind   = kind_t'(c);
      r.handle = HANDLE_W'(queued_handle[c][idx]);
      r.stamp  = queued_stamp[c][idx];
      queue_head[c] = (idx + 1) % DEPTH;
      queue_count[c]--;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return HANDLE_W'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic issue_request(op_t op, kind_t k, logic [HANDLE_W-1:0] h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    kind        <= k;
    item_handle <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_responses.push_back(apply_request(op, k, h));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    fifo_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_responses.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status=%0d stamp=%0h", status, out_stamp));
      end else begin
        want = expected_responses.pop_front();
        if (status !== want.status)
          flag_mismatch($sformatf("status %0d, want %s", status, want.status.name()));
        if (out_kind !== want.kind)
          flag_mismatch($sformatf("out_kind %0b, want %0b", out_kind, want.kind));
        if (out_handle !== want.handle)
          flag_mismatch($sformatf("out_handle %0h, want %0h", out_handle, want.handle));
        if (out_stamp !== want.stamp)
          flag_mismatch($sformatf("out_stamp %0h, want %0h", out_stamp, want.stamp));
      end
    end
  end

  // receiver stalls
  initial begin
    int run;
    int stall;
    out_ready <= 1'b1;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_empty_queues();
    issue_request(OP_DEQUEUE, KIND_FIRST, '1);
    issue_request(OP_DEQUEUE, KIND_SECOND, '0);
  endtask

  task automatic test_class_full();
    logic [HANDLE_W-1:0] h;
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0: h = '0;
        1: h = '1;
        2: h = 16'h5555;
        3: h = 16'haaaa;
        default: h = pick_handle();
      endcase
      issue_request(OP_ENQUEUE, KIND_FIRST, h);
    end
    issue_request(OP_ENQUEUE, KIND_FIRST, 16'hbeef);
    issue_request(OP_ENQUEUE, KIND_SECOND, '1);
    issue_request(OP_DEQUEUE, KIND_SECOND, '1);
    issue_request(OP_DEQUEUE, KIND_FIRST, '0);
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 8; i++)
      issue_request(OP_ENQUEUE, kind_t'($urandom_range(0, 1)), pick_handle());
    wait_for_results();
  endtask

  task automatic test_random_traffic(int unsigned total);
    int unsigned sent;
    int          phase_len;
    int          enq_pct;
    int          second_pct;
    op_t         op;
    kind_t       k;
    sent = 0;
    while (sent < total) begin
      phase_len = $urandom_range(40, 160);
      case ($urandom_range(0, 3))
        0: enq_pct = 25;
        1: enq_pct = 50;
        2: enq_pct = 70;
        default: enq_pct = 95;
      endcase
      case ($urandom_range(0, 2))
        0: second_pct = 10;
        1: second_pct = 50;
        default: second_pct = 90;
      endcase
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < phase_len; i++) begin
        op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
        k  = ($urandom_range(0, 99) < second_pct) ? KIND_SECOND : KIND_FIRST;
        issue_request(op, k, pick_handle());
      end
      sent += phase_len;
    end
    steady = 1'b0;
  endtask

  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    operation      <= OP_ENQUEUE;
    kind           <= KIND_FIRST;
    item_handle    <= '0;
    steady         = 1'b0;
    mismatch_count = 0;
    stamp_counter  = '0;
    queue_head     = '{0, 0};
    queue_count    = '{0, 0};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_queues();
    test_class_full();
    test_drain_pause();
    test_random_traffic(900);
    test_drain_pause();
    test_random_traffic(900);

    wait_for_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_responses.size() == 0) begin
      $display("age_ordered_two_class_fifo_top verification clean");
    end else begin
      $display("age_ordered_two_class_fifo_top verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("age_ordered_two_class_fifo_top verification failed");
    $finish;
  end

endmodule
